### hw/rtl/tlbpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbpt_pkg: shared types and constants of the TLB page translator
// Fixed field widths and the command/status bundles that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

  localparam int ADDR_W  = 16;
  localparam int COUNT_W = 32;

  // Controller to datapath
  typedef struct packed {
    logic clear_en;   // write one zero row of the page table
    logic capture;    // take the incoming virtual address
    logic reduce;     // one multiply or subtract step of the page reduction
    logic commit;     // resolve the translation, update state, load the result
  } tlbpt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_done;  // page table sweep finished
    logic reduce_done; // page number is final
    logic out_busy;    // result register holds a transfer not yet taken
  } tlbpt_sts_t;

endpackage

### hw/rtl/tlbpt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbpt_if: request and response channels of the TLB page translator
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface tlbpt_req_if;
  logic                         valid;
  logic                         ready;
  logic [tlbpt_pkg::ADDR_W-1:0] virtual_address;

  modport source (output valid, output virtual_address, input ready);
  modport sink   (input valid, input virtual_address, output ready);
endinterface

interface tlbpt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [tlbpt_pkg::ADDR_W-1:0]  physical_address;
  logic                          tlb_hit;
  logic                          page_fault;
  logic [tlbpt_pkg::COUNT_W-1:0] translated_count;
  logic [tlbpt_pkg::COUNT_W-1:0] miss_count;
  logic [tlbpt_pkg::COUNT_W-1:0] fault_count;

  modport source (output valid, output physical_address, output tlb_hit,
                  output page_fault, output translated_count, output miss_count,
                  output fault_count, input ready);
  modport sink   (input valid, input physical_address, input tlb_hit,
                  input page_fault, input translated_count, input miss_count,
                  input fault_count, output ready);
endinterface

### hw/rtl/tlbpt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbpt_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tlbpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/tlbpt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbpt_ctrl: sequencing state machine of the TLB page translator
// Runs the page table sweep after reset, then steps each request through
// capture, page reduction and commit.
// ----------------------------------------------------------------------------
module tlbpt_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  output tlbpt_pkg::tlbpt_cmd_t cmd,
  input  tlbpt_pkg::tlbpt_sts_t sts
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_REDUCE,
    S_RESOLVE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (sts.clear_done) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            state <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          // page is final in this cycle; the lookup reads launch now
          if (sts.reduce_done) begin
            state <= S_RESOLVE;
          end
        end
        S_RESOLVE: begin
          // hold until the result register can take the new transfer
          if (!sts.out_busy) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  assign req_ready    = (state == S_IDLE);
  assign cmd.clear_en = (state == S_CLEAR);
  assign cmd.capture  = (state == S_IDLE) && req_valid;
  assign cmd.reduce   = (state == S_REDUCE) && !sts.reduce_done;
  assign cmd.commit   = (state == S_RESOLVE) && !sts.out_busy;

endmodule

### hw/rtl/tlbpt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbpt_dp: datapath of the TLB page translator
// TLB tag compare, page table and TLB frame memories, frame allocator,
// saturating counters and the result register.
// ----------------------------------------------------------------------------
module tlbpt_dp #(
  parameter int TLB_ENTRIES = 16,
  parameter int PAGE_COUNT  = 256,
  parameter int FRAME_COUNT = 256,
  parameter int OFFSET_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tlbpt_pkg::tlbpt_cmd_t        cmd,
  output tlbpt_pkg::tlbpt_sts_t        sts,
  input  logic [tlbpt_pkg::ADDR_W-1:0] va_in,
  tlbpt_rsp_if.source                  rsp
);

  localparam int ADDR_W    = tlbpt_pkg::ADDR_W;
  localparam int COUNT_W   = tlbpt_pkg::COUNT_W;
  localparam int TW        = $clog2(TLB_ENTRIES);
  localparam int PGW       = $clog2(PAGE_COUNT);
  localparam int FW        = $clog2(FRAME_COUNT);
  localparam int RAW_W     = (ADDR_W > OFFSET_BITS) ? (ADDR_W - OFFSET_BITS) : 1;
  localparam bit PAGE_POW2 = ((PAGE_COUNT & (PAGE_COUNT - 1)) == 0);
  localparam int RED_STEPS = PAGE_POW2 ? 0 : 2;
  localparam int RCP_W     = RAW_W + 1;
  localparam int PROD_W    = RAW_W + RCP_W;
  localparam int RED_SHIFT = RAW_W + PGW;
  localparam longint unsigned RCP_FULL =
    ((64'd1 << RED_SHIFT) + 64'(PAGE_COUNT) - 64'd1) / 64'(PAGE_COUNT);
  localparam logic [RCP_W-1:0]   RCP       = RCP_W'(RCP_FULL);
  localparam logic [31:0]        OFF_MASK  = (32'd1 << OFFSET_BITS) - 32'd1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
  endfunction

  // request and page reduction
  logic [ADDR_W-1:0] va_q;
  logic [RAW_W-1:0]  rem;
  logic [1:0]        red_cnt;
  logic [RAW_W-1:0]  quo;
  logic [PROD_W-1:0] red_prod;
  logic [PGW-1:0]    page;

  // page table sweep
  logic [PGW-1:0] clr_idx;
  logic           clear_done;

  // TLB
  logic [PGW-1:0]         tag [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] tlb_valid;
  logic [TW-1:0]          victim;
  logic                   hit;
  logic [TW-1:0]          hit_idx;
  logic                   hit_q;
  logic [FW-1:0]          tlb_rdata;

  // page table memory: {mapped, frame}
  logic              pt_we;
  logic [PGW-1:0]    pt_waddr;
  logic [FW:0]       pt_wdata;
  logic [FW:0]       pt_rdata;
  logic              mapped;

  // allocation and result
  logic [FW-1:0]      cursor;
  logic [FW-1:0]      frame_sel;
  logic               fault;
  logic [ADDR_W-1:0]  pa;
  logic [COUNT_W-1:0] trans_cnt, miss_cnt, fault_cnt;
  logic [COUNT_W-1:0] trans_next, miss_next, fault_next;

  logic               out_valid;
  logic [ADDR_W-1:0]  out_pa;
  logic               out_hit, out_fault;
  logic [COUNT_W-1:0] out_trans, out_miss, out_faults;

  // Page number: truncation is the modulo for a power-of-two table;
  // otherwise a reciprocal multiply registers the quotient in quo and a
  // subtract then leaves the remainder in rem.
  assign page     = PGW'(rem);
  assign red_prod = PROD_W'(rem) * PROD_W'(RCP);

  always_ff @(posedge clk) begin
    if (rst) begin
      red_cnt <= '0;
    end else if (cmd.capture) begin
      red_cnt <= 2'(RED_STEPS);
    end else if (cmd.reduce) begin
      red_cnt <= red_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      va_q <= va_in;
      rem  <= RAW_W'(va_in >> OFFSET_BITS);
    end else if (cmd.reduce) begin
      if (red_cnt == 2'd2) begin
        quo <= RAW_W'(red_prod >> RED_SHIFT);
      end else begin
        rem <= RAW_W'(32'(rem) - 32'(quo) * 32'(PAGE_COUNT));
      end
    end
  end

  // Sweep the page table to unmapped after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx    <= '0;
      clear_done <= 1'b0;
    end else if (cmd.clear_en) begin
      if (clr_idx == PGW'(PAGE_COUNT - 1)) begin
        clear_done <= 1'b1;
      end
      clr_idx <= clr_idx + PGW'(1);
    end
  end

  // Fully associative tag compare, lowest matching entry wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tlb_valid[i] && (tag[i] == page)) begin
        hit     = 1'b1;
        hit_idx = TW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_q <= hit;
  end

  tlbpt_ram #(
    .WIDTH (FW + 1),
    .DEPTH (PAGE_COUNT)
  ) u_page_table (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .raddr (page),
    .rdata (pt_rdata)
  );

  tlbpt_ram #(
    .WIDTH (FW),
    .DEPTH (TLB_ENTRIES)
  ) u_tlb_frame (
    .clk   (clk),
    .we    (cmd.commit && !hit_q),
    .waddr (victim),
    .wdata (frame_sel),
    .raddr (hit_idx),
    .rdata (tlb_rdata)
  );

  assign mapped    = pt_rdata[FW];
  assign fault     = !hit_q && !mapped;
  assign frame_sel = hit_q  ? tlb_rdata :
                     mapped ? pt_rdata[FW-1:0] : cursor;
  assign pa        = ADDR_W'((32'(frame_sel) << OFFSET_BITS) | (32'(va_q) & OFF_MASK));

  // Stop writing once the last row is cleared
  assign pt_we    = (cmd.clear_en && !clear_done) || (cmd.commit && fault);
  assign pt_waddr = cmd.clear_en ? clr_idx : page;
  assign pt_wdata = cmd.clear_en ? '0 : {1'b1, cursor};

  assign trans_next = sat_inc(trans_cnt);
  assign miss_next  = hit_q ? miss_cnt : sat_inc(miss_cnt);
  assign fault_next = fault ? sat_inc(fault_cnt) : fault_cnt;

  // Control state: valid bits, pointers, counters, result flag
  always_ff @(posedge clk) begin
    if (rst) begin
      tlb_valid <= '0;
      victim    <= '0;
      cursor    <= '0;
      trans_cnt <= '0;
      miss_cnt  <= '0;
      fault_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        if (!hit_q) begin
          tlb_valid[victim] <= 1'b1;
          victim <= (victim == TW'(TLB_ENTRIES - 1)) ? '0 : victim + TW'(1);
        end
        if (fault) begin
          cursor <= (cursor == FW'(FRAME_COUNT - 1)) ? '0 : cursor + FW'(1);
        end
        trans_cnt <= trans_next;
        miss_cnt  <= miss_next;
        fault_cnt <= fault_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: TLB tags and result fields
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (!hit_q) begin
        tag[victim] <= page;
      end
      out_pa     <= pa;
      out_hit    <= hit_q;
      out_fault  <= fault;
      out_trans  <= trans_next;
      out_miss   <= miss_next;
      out_faults <= fault_next;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.physical_address = out_pa;
  assign rsp.tlb_hit          = out_hit;
  assign rsp.page_fault       = out_fault;
  assign rsp.translated_count = out_trans;
  assign rsp.miss_count       = out_miss;
  assign rsp.fault_count      = out_faults;

  assign sts.clear_done  = clear_done;
  assign sts.reduce_done = (red_cnt == '0);
  assign sts.out_busy    = out_valid && !rsp.ready;

endmodule

### hw/rtl/tlb_page_table_translator.sv
`timescale 1ns / 1ps
// Sequence: a request is captured, its page number is reduced by a reciprocal
//   multiply and a subtract when PAGE_COUNT is not a power of two, the lookup
//   reads are registered, and the commit step loads the result register.
// Requests: a new request is taken only once the last one is committed.
// Reset: synchronous; after rst falls the page table is swept to unmapped and
//   request.ready stays low until the sweep finishes.
// ----------------------------------------------------------------------------
// tlb_page_table_translator: TLB-fronted virtual to physical translator
// Looks each page up in a fully associative TLB with FIFO replacement,
// falls back to a page table, and allocates frames in order on a fault.
// ----------------------------------------------------------------------------
module tlb_page_table_translator #(
  parameter int TLB_ENTRIES = 16,
  parameter int PAGE_COUNT  = 256,
  parameter int FRAME_COUNT = 256,
  parameter int OFFSET_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  tlbpt_req_if.sink   request,
  tlbpt_rsp_if.source response
);

  // Command and status between the sequencer and the datapath
  tlbpt_pkg::tlbpt_cmd_t cmd;
  tlbpt_pkg::tlbpt_sts_t sts;

  // Sequencer: sweep after reset, then capture -> reduce/lookup -> commit.
  // Request ready is high only in the idle state; the result register in
  // the datapath lets a new request enter while the last result waits.
  tlbpt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath: tag compare and memory reads launch in the last reduce cycle,
  // the commit step picks the frame (TLB, page table or next free frame),
  // updates TLB, page table and counters, and loads the response transfer.
  tlbpt_dp #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .PAGE_COUNT  (PAGE_COUNT),
    .FRAME_COUNT (FRAME_COUNT),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .sts   (sts),
    .va_in (request.virtual_address),
    .rsp   (response)
  );

endmodule
